// ===== hw/rtl/dqod_pkg.sv =====
// Shared types and constants for the double-ended queue with ordered dump.
package dqod_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int ENTRY_W      = 5;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DUMP_FWD   = 3'd4,
    CMD_DUMP_BWD   = 3'd5,
    CMD_COUNT      = 3'd6,
    CMD_DUMP_BOTH  = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_t;

  typedef struct packed {
    cmd_t                       command;
    logic signed [VALUE_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  value_out;
    status_t                    status;
    logic [ENTRY_W-1:0]         entry_count;
    logic                       last;
  } out_item_t;

endpackage

// ===== hw/rtl/deque_with_ordered_dump_core.sv =====
// Top level of the bounded double-ended queue with ordered dump.
// A request is taken when start is high and busy is low. Push, pop and count
// requests give one result on the cycle after acceptance and leave busy low, so
// one such request can be taken every cycle. A dump of N held entries keeps busy
// high while it issues N reads (2*N for dump-both), one read of the entry store's
// single read port per cycle; its results follow the registered dump state and the
// store's registered read data, one per cycle, with last set on the final one, and
// busy falls in the cycle after the final read is issued. A dump, pop or push that
// finds the queue empty or full gives a single status result. Results are shown on
// out_data for one cycle under out_strobe and the receiver cannot stall them.
module deque_with_ordered_dump_core
  import dqod_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_strobe,
  output out_item_t out_data
);

  localparam int PTR_W = $clog2(CAPACITY);

  logic                      wr_en;
  logic [PTR_W-1:0]          wr_addr;
  logic signed [VALUE_W-1:0] wr_data;
  logic [PTR_W-1:0]          rd_addr;
  logic signed [VALUE_W-1:0] rd_data;

  dqod_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  dqod_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ===== hw/rtl/dqod_mem.sv =====
// Entry store: one write port and one read port with registered read data.
module dqod_mem
  import dqod_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic signed [VALUE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic signed [VALUE_W-1:0] rd_data
);

  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/dqod_ctrl.sv =====
// Command sequencer: ring pointers, occupancy, dump read sequencing and results.
module dqod_ctrl
  import dqod_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int PTR_W = $clog2(CAPACITY),
  parameter int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  in_item_t                  in_data,
  output logic                      out_strobe,
  output out_item_t                 out_data,
  output logic                      wr_en,
  output logic [PTR_W-1:0]          wr_addr,
  output logic signed [VALUE_W-1:0] wr_data,
  output logic [PTR_W-1:0]          rd_addr,
  input  logic signed [VALUE_W-1:0] rd_data
);

  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                               input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (PTR_W+1)'(CAPACITY)) begin
      sum = sum - (PTR_W+1)'(CAPACITY);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? LAST_IDX : p - PTR_W'(1);
  endfunction

  state_t           state_r, state_nxt;
  logic [PTR_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [PTR_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             both_r, both_nxt;
  logic             bwd_r, bwd_nxt;
  logic             simple_valid_r, simple_valid_nxt;
  status_t          status_r, status_nxt;
  logic             dump_valid_r, dump_valid_nxt;
  logic             dump_last_r, dump_last_nxt;

  logic accept;
  logic is_full;
  logic is_empty;
  logic dump_go;

  assign accept   = start && !busy;
  assign is_full  = (occ_r >= FULL_CNT);
  assign is_empty = (occ_r == '0);
  assign busy     = (state_r != ST_IDLE);

  always_comb begin
    dump_go = 1'b0;
    if (accept && !is_empty) begin
      case (in_data.command)
        CMD_DUMP_FWD, CMD_DUMP_BWD, CMD_DUMP_BOTH: dump_go = 1'b1;
        default: dump_go = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (dump_go) begin
          state_nxt = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (rem_r == CNT_W'(1) && !both_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    front_nxt        = front_r;
    occ_nxt          = occ_r;
    idx_nxt          = idx_r;
    rem_nxt          = rem_r;
    both_nxt         = both_r;
    bwd_nxt          = bwd_r;
    simple_valid_nxt = 1'b0;
    status_nxt       = status_r;
    dump_valid_nxt   = 1'b0;
    dump_last_nxt    = dump_last_r;
    wr_en            = 1'b0;
    wr_addr          = ring_dec(front_r);
    wr_data          = in_data.value;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          simple_valid_nxt = !dump_go;
          status_nxt       = STS_OK;
          unique case (in_data.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              if (is_full) begin
                status_nxt = STS_FULL;
              end else begin
                wr_en   = 1'b1;
                occ_nxt = occ_r + CNT_W'(1);
                if (in_data.command == CMD_PUSH_FRONT) begin
                  wr_addr   = ring_dec(front_r);
                  front_nxt = ring_dec(front_r);
                end else begin
                  wr_addr = ring_add(front_r, PTR_W'(occ_r));
                end
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (is_empty) begin
                status_nxt = STS_EMPTY;
              end else begin
                occ_nxt = occ_r - CNT_W'(1);
                if (in_data.command == CMD_POP_FRONT) begin
                  front_nxt = ring_inc(front_r);
                end
              end
            end
            CMD_COUNT: begin
              status_nxt = STS_OK;
            end
            CMD_DUMP_FWD, CMD_DUMP_BWD, CMD_DUMP_BOTH: begin
              if (is_empty) begin
                status_nxt = STS_EMPTY;
              end else begin
                rem_nxt  = occ_r;
                both_nxt = (in_data.command == CMD_DUMP_BOTH);
                bwd_nxt  = (in_data.command != CMD_DUMP_FWD);
                if (in_data.command == CMD_DUMP_FWD) begin
                  idx_nxt = front_r;
                end else begin
                  idx_nxt = ring_add(front_r, PTR_W'(occ_r - CNT_W'(1)));
                end
              end
            end
            default: status_nxt = STS_OK;
          endcase
        end
      end
      ST_DUMP: begin
        dump_valid_nxt = 1'b1;
        dump_last_nxt  = (rem_r == CNT_W'(1)) && !both_r;
        if (rem_r == CNT_W'(1)) begin
          if (both_r) begin
            idx_nxt  = front_r;
            rem_nxt  = occ_r;
            both_nxt = 1'b0;
            bwd_nxt  = 1'b0;
          end
        end else begin
          rem_nxt = rem_r - CNT_W'(1);
          idx_nxt = bwd_r ? ring_dec(idx_r) : ring_inc(idx_r);
        end
      end
      default: begin
        dump_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      front_r        <= '0;
      occ_r          <= '0;
      simple_valid_r <= 1'b0;
      dump_valid_r   <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      front_r        <= front_nxt;
      occ_r          <= occ_nxt;
      simple_valid_r <= simple_valid_nxt;
      dump_valid_r   <= dump_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    rem_r       <= rem_nxt;
    both_r      <= both_nxt;
    bwd_r       <= bwd_nxt;
    status_r    <= status_nxt;
    dump_last_r <= dump_last_nxt;
  end

  assign rd_addr    = idx_r;
  assign out_strobe = simple_valid_r || dump_valid_r;

  always_comb begin
    out_data.value_out   = dump_valid_r ? rd_data : '0;
    out_data.status      = dump_valid_r ? STS_OK : status_r;
    out_data.entry_count = ENTRY_W'(occ_r);
    out_data.last        = dump_valid_r ? dump_last_r : 1'b1;
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL_CNT)
    else $error("occupancy exceeds capacity");

  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(simple_valid_r && dump_valid_r))
    else $error("simple and dump results collide");

  a_no_write_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_IDLE))
    else $error("store written during a dump");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_full && (in_data.command == CMD_PUSH_FRONT ||
     in_data.command == CMD_PUSH_BACK)) |=> (occ_r == $past(occ_r) + CNT_W'(1)))
    else $error("accepted push did not raise occupancy");

  a_dump_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(state_r) == ST_DUMP) |-> (dump_valid_r && dump_last_r))
    else $error("dump finished without a final result");

endmodule
